// ===== sv/hgs_pkg.sv =====
`timescale 1ns / 1ps

package hgs_pkg;

  localparam int unsigned RingW  = 4;
  localparam int unsigned PosW   = 7;
  localparam int unsigned CellW  = 10;
  localparam int unsigned CoordW = 5;

  // Largest ring count the block enumerates; larger settings saturate
  localparam logic [RingW-1:0] MaxRings = 4'd15;

  // Reset value of the ring count register
  localparam logic [RingW-1:0] RingsReset = 4'd1;

  // Current cell of the walk, as seen by the coordinate logic
  typedef struct packed {
    logic [RingW-1:0] ring;
    logic [PosW-1:0]  pos;
    logic [CellW-1:0] num;
    logic             last;
  } cell_t;

  // Number of cells in ring n: 6n = 4n + 2n
  function automatic logic [PosW-1:0] ring_span(input logic [RingW-1:0] n);
    logic [PosW-1:0] n_ext;
    begin
      n_ext = {{(PosW-RingW){1'b0}}, n};
      return (n_ext << 2) + (n_ext << 1);
    end
  endfunction

endpackage

// ===== sv/hgs_wave.sv =====
`timescale 1ns / 1ps

// Clamped triangle wave over the six sides of ring n, closed form
module hgs_wave
  import hgs_pkg::*;
(
  input  logic [RingW-1:0]         n_i,
  input  logic [PosW-1:0]          k_i,
  output logic signed [CoordW-1:0] w_o
);

  logic signed [PosW:0] n_s;
  logic signed [PosW:0] k_s;
  logic signed [PosW:0] w_full;

  assign n_s = $signed({{(PosW+1-RingW){1'b0}}, n_i});
  assign k_s = $signed({1'b0, k_i});

  // Pick the side: falling edge, bottom flat, rising edge, top flat, falling edge
  always_comb begin
    if (k_s < n_s) begin
      w_full = -k_s;
    end else if (k_s < (n_s <<< 1)) begin
      w_full = -n_s;
    end else if (k_s < (n_s <<< 2)) begin
      w_full = k_s - (n_s <<< 1) - n_s;
    end else if (k_s < (n_s <<< 2) + n_s) begin
      w_full = n_s;
    end else begin
      w_full = (n_s <<< 2) + (n_s <<< 1) - k_s;
    end
  end

  assign w_o = w_full[CoordW-1:0];

endmodule

// ===== sv/hgs_walk.sv =====
`timescale 1ns / 1ps

// Spiral walk state: ring, position in ring and running cell index
module hgs_walk
  import hgs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic             restart_i,
  input  logic [RingW-1:0] size_i,
  output cell_t            cell_o
);

  logic [RingW-1:0] ring_q, ring_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [CellW-1:0] cell_q, cell_d;

  logic             go_origin;
  logic [RingW-1:0] cur_ring;
  logic [PosW-1:0]  cur_pos;
  logic [CellW-1:0] cur_cell;
  logic             cur_last;
  logic             ring_end;

  // Restart on request, on a ring beyond the grid, or on a position off the ring
  assign go_origin = restart_i || (ring_q > size_i) ||
                     ((ring_q != '0) && (pos_q >= ring_span(ring_q)));

  assign cur_ring = go_origin ? '0 : ring_q;
  assign cur_pos  = go_origin ? '0 : pos_q;
  assign cur_cell = go_origin ? '0 : cell_q;

  assign cur_last = (cur_ring == size_i) &&
                    ((size_i == '0) || (cur_pos == ring_span(size_i) - 1'b1));

  assign ring_end = (cur_ring == '0) || (cur_pos == ring_span(cur_ring) - 1'b1);

  // Next cell: wrap to origin after the last one, else step along the ring or on to the next ring
  always_comb begin
    if (cur_last) begin
      ring_d = '0;
      pos_d  = '0;
      cell_d = '0;
    end else begin
      cell_d = cur_cell + 1'b1;
      if (ring_end) begin
        ring_d = cur_ring + 1'b1;
        pos_d  = '0;
      end else begin
        ring_d = cur_ring;
        pos_d  = cur_pos + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_q <= '0;
      pos_q  <= '0;
      cell_q <= '0;
    end else if (adv_i) begin
      ring_q <= ring_d;
      pos_q  <= pos_d;
      cell_q <= cell_d;
    end
  end

  assign cell_o.ring = cur_ring;
  assign cell_o.pos  = cur_pos;
  assign cell_o.num  = cur_cell;
  assign cell_o.last = cur_last;

endmodule

// ===== sv/hex_grid_spiral_generator.sv =====
`timescale 1ns / 1ps

// Hexagonal grid spiral generator.
// Every word accepted on the input channel (in_valid_i / in_ready_o) produces
// one word on the output channel (out_valid_o / out_ready_i): the cube
// coordinates of the next cell of the spiral, its ring, its running index and
// a flag on the final cell. restart_i = 1 emits the origin and restarts there;
// after the flagged last cell the walk wraps to the origin by itself.
// cfg_we_i writes the ring count from cfg_wdata_i; write it only
// while no word is in flight.
// The result is registered and shows in the cycle after acceptance.
// Throughput: one word per cycle unless the receiver stalls; the walk state
// and coordinate logic sit between the walk registers and the output register
// with no loop. A stalled receiver holds the output word; a new input word is
// still taken in the cycle the receiver frees the output register.
// Reset: ring count 1, walk at the origin, output register empty.
module hex_grid_spiral_generator
  import hgs_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [RingW-1:0]         cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     restart_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [CoordW-1:0] q_coord_o,
  output logic signed [CoordW-1:0] r_coord_o,
  output logic signed [CoordW-1:0] s_coord_o,
  output logic [RingW-1:0]         ring_number_o,
  output logic [CellW-1:0]         cell_number_o,
  output logic                     last_cell_o
);

  logic [RingW-1:0] rings_q;
  logic [RingW-1:0] size;
  logic             accept;
  cell_t            cur;

  logic [PosW:0]    k_sum;
  logic [PosW:0]    span_ext;
  logic [PosW-1:0]  k_rot;

  logic signed [CoordW-1:0] q_w, r_w;
  logic signed [CoordW:0]   s_full;

  logic                     out_valid_q;
  logic signed [CoordW-1:0] q_q, r_q, s_q;
  logic [RingW-1:0]         ring_q;
  logic [CellW-1:0]         cell_q;
  logic                     last_q;

  // Ring count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rings_q <= RingsReset;
    end else if (cfg_we_i) begin
      rings_q <= cfg_wdata_i;
    end
  end

  assign size = (rings_q > MaxRings) ? MaxRings : rings_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  hgs_walk u_walk (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (accept),
    .restart_i (restart_i),
    .size_i    (size),
    .cell_o    (cur)
  );

  // r uses the wave shifted by four sixths of the ring
  assign span_ext = {1'b0, ring_span(cur.ring)};
  assign k_sum    = {1'b0, cur.pos} + {1'b0, ({{(PosW-RingW){1'b0}}, cur.ring} << 2)};
  always_comb begin
    if (k_sum >= span_ext) begin
      k_rot = PosW'(k_sum - span_ext);
    end else begin
      k_rot = k_sum[PosW-1:0];
    end
  end

  hgs_wave u_wave_q (
    .n_i (cur.ring),
    .k_i (cur.pos),
    .w_o (q_w)
  );

  hgs_wave u_wave_r (
    .n_i (cur.ring),
    .k_i (k_rot),
    .w_o (r_w)
  );

  assign s_full = -{q_w[CoordW-1], q_w} - {r_w[CoordW-1], r_w};

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      q_q    <= q_w;
      r_q    <= r_w;
      s_q    <= s_full[CoordW-1:0];
      ring_q <= cur.ring;
      cell_q <= cur.num;
      last_q <= cur.last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign q_coord_o     = q_q;
  assign r_coord_o     = r_q;
  assign s_coord_o     = s_q;
  assign ring_number_o = ring_q;
  assign cell_number_o = cell_q;
  assign last_cell_o   = last_q;

endmodule

// ===== sv/hgs_checker.sv =====
`timescale 1ns / 1ps

module hgs_checker
  import hgs_pkg::*;
(
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_o,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic signed [CoordW-1:0] q_coord_o,
  input logic signed [CoordW-1:0] r_coord_o,
  input logic signed [CoordW-1:0] s_coord_o,
  input logic [RingW-1:0]         ring_number_o,
  input logic [CellW-1:0]         cell_number_o,
  input logic                     last_cell_o
);

  logic [CoordW-1:0] coord_sum;
  assign coord_sum = q_coord_o + r_coord_o + s_coord_o;

  // An accepted word always shows up on the output next cycle
  a_accept_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted word did not reach the output");

  // Input is never blocked while the output register is empty
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output register");

  // Cube coordinates sum to zero
  a_cube_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> coord_sum == '0)
    else $error("q + r + s is not zero");

  // Origin has zero coordinates
  a_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ring_number_o == '0 |-> q_coord_o == '0 && r_coord_o == '0)
    else $error("origin word carries nonzero coordinates");

  // A stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(cell_number_o) &&
    $stable(last_cell_o))
    else $error("stalled output word changed");

endmodule

bind hex_grid_spiral_generator hgs_checker u_hgs_checker (.*);

// ===== tb/tb_hex_grid_spiral_generator.sv =====
`timescale 1ns / 1ps

module tb_hex_grid_spiral_generator;
  import hgs_pkg::*;

  // Cycles with no word moving on either channel before the run is abandoned
  localparam int unsigned QuietLimit = 4000;

  // One emitted cell as the block should present it
  typedef struct {
    logic signed [CoordW-1:0] q;
    logic signed [CoordW-1:0] r;
    logic signed [CoordW-1:0] s;
    logic [RingW-1:0]         ring;
    logic [CellW-1:0]         num;
    logic                     last;
  } cell_word_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_we = 1'b0;
  logic [RingW-1:0]         cfg_wdata = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic                     restart = 1'b0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [CoordW-1:0] q_coord;
  logic signed [CoordW-1:0] r_coord;
  logic signed [CoordW-1:0] s_coord;
  logic [RingW-1:0]         ring_number;
  logic [CellW-1:0]         cell_number;
  logic                     last_cell;

  // Restart bits waiting to be sent, cells waiting to come out
  bit         restart_feed[$];
  cell_word_t cell_expect[$];

  // Walk state and ring count as the block should hold them
  logic [RingW-1:0] rings_setting = RingsReset;
  logic [RingW-1:0] walk_ring = '0;
  logic [PosW-1:0]  walk_pos = '0;
  logic [CellW-1:0] walk_cell = '0;

  bit          in_idle_on = 1'b1;
  bit          out_idle_on = 1'b1;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned error_count = 0;

  hex_grid_spiral_generator i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .restart_i     (restart),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .q_coord_o     (q_coord),
    .r_coord_o     (r_coord),
    .s_coord_o     (s_coord),
    .ring_number_o (ring_number),
    .cell_number_o (cell_number),
    .last_cell_o   (last_cell)
  );

  always #10 clk_i = ~clk_i;

  // Clamped triangle wave over the six sides of ring n
  function automatic int side_wave(int k, int n);
    if (k < n) return -k;
    if (k < 2 * n) return -n;
    if (k < 4 * n) return k - 3 * n;
    if (k < 5 * n) return n;
    return 6 * n - k;
  endfunction

  // Emit the cell for one word and advance the walk
  function automatic cell_word_t next_cell(logic restart_bit);
    cell_word_t w;
    int size;
    int n;
    int k;
    int q;
    int r;
    int s;
    size = (rings_setting > MaxRings) ? int'(MaxRings) : int'(rings_setting);
    n = int'(walk_ring);
    k = int'(walk_pos);
    // restart, ring beyond the current setting, or a position off the ring
    if (restart_bit || n > size || (n != 0 && k >= 6 * n)) begin
      walk_ring = '0;
      walk_pos = '0;
      walk_cell = '0;
      n = 0;
      k = 0;
    end
    q = 0;
    r = 0;
    if (n != 0) begin
      q = side_wave(k, n);
      r = side_wave((k + 4 * n) % (6 * n), n);
    end
    s = -q - r;
    w.q = q[CoordW-1:0];
    w.r = r[CoordW-1:0];
    w.s = s[CoordW-1:0];
    w.ring = walk_ring;
    w.num = walk_cell;
    w.last = (n == size) && (size == 0 || k == 6 * size - 1);
    if (w.last) begin
      walk_ring = '0;
      walk_pos = '0;
      walk_cell = '0;
    end else begin
      if (n == 0 || k == 6 * n - 1) begin
        walk_ring = walk_ring + 1'b1;
        walk_pos = '0;
      end else begin
        walk_pos = walk_pos + 1'b1;
      end
      walk_cell = walk_cell + 1'b1;
    end
    return w;
  endfunction

  // Mostly short pauses, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return $urandom_range(1, 3);
    if (roll < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  // Sender: predict on acceptance, then present the next word or idle
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready) cell_expect.push_back(next_cell(restart));
      if (!in_valid || in_ready) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (restart_feed.size() != 0) begin
          in_valid <= 1'b1;
          restart <= restart_feed.pop_front();
          send_gap <= (in_idle_on && $urandom_range(0, 9) < 3) ? idle_len() : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each accepted word, stall at random
  always @(posedge clk_i) begin
    cell_word_t want;
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        if (cell_expect.size() == 0) begin
          $display("%0t: unexpected word, actual q=%0d r=%0d s=%0d cell=%0d", $time,
                   q_coord, r_coord, s_coord, cell_number);
          error_count++;
        end else begin
          want = cell_expect.pop_front();
          check_field("q_coord", want.q, q_coord);
          check_field("r_coord", want.r, r_coord);
          check_field("s_coord", want.s, s_coord);
          check_field("ring_number", want.ring, ring_number);
          check_field("cell_number", want.num, cell_number);
          check_field("last_cell", want.last, last_cell);
        end
      end
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_ready <= 1'b0;
      end else if (out_idle_on && $urandom_range(0, 6) == 0) begin
        stall_left <= idle_len();
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog on traffic
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == QuietLimit) begin
        $display("DONE: errors detected");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Ring count write; only issued with nothing in flight
  task automatic write_rings(logic [RingW-1:0] v);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    rings_setting = v;
  endtask

  // Queue count words, restart set with the given percentage
  task automatic queue_scan(int count, int restart_pct, inout int total);
    @(negedge clk_i);
    for (int i = 0; i < count; i++) begin
      restart_feed.push_back($urandom_range(0, 99) < restart_pct);
    end
    total += count;
  endtask

  task automatic push_word(bit b, inout int total);
    @(negedge clk_i);
    restart_feed.push_back(b);
    total++;
  endtask

  // Wait until every queued word is sent and every expected word is back
  task automatic drain();
    while (restart_feed.size() != 0 || in_valid || cell_expect.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (2) @(negedge clk_i);
  endtask

  initial begin
    int total;
    int roll;
    logic [RingW-1:0] rings;
    total = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset setting of one ring: full ring, wrap, then a restart at the start of ring one
    queue_scan(8, 0, total);
    push_word(1'b1, total);
    push_word(1'b0, total);
    drain();

    // Zero rings: origin only, always last
    write_rings(4'd0);
    push_word(1'b0, total);
    push_word(1'b0, total);
    push_word(1'b1, total);
    push_word(1'b0, total);
    drain();

    // Two rings, stop part way into ring two
    write_rings(4'd2);
    queue_scan(9, 0, total);
    drain();

    // Ring count lowered below the current ring
    write_rings(4'd1);
    queue_scan(2, 0, total);
    drain();

    // Largest grid, rest of the scan through the last cell, then wrap
    write_rings(MaxRings);
    queue_scan(725, 0, total);
    drain();

    // Random settings, mostly plain walks with occasional restarts
    while (total < 1100) begin
      roll = $urandom_range(0, 9);
      if (roll == 0) rings = '0;
      else if (roll == 1) rings = MaxRings;
      else rings = RingW'($urandom_range(1, 14));
      write_rings(rings);
      @(negedge clk_i);
      in_idle_on = ($urandom_range(0, 3) != 0);
      out_idle_on = ($urandom_range(0, 3) != 0);
      queue_scan($urandom_range(5, 60), $urandom_range(0, 8), total);
      drain();
    end

    repeat (4) @(posedge clk_i);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
